FILE: hdl/cdsp_pkg.sv
package cdsp_pkg;

  localparam int DT_W   = 16;
  localparam int POS_W  = 32;
  localparam int HL_W   = 24;
  localparam int WIDE_W = 34;
  localparam int EXT_W  = 36;
  localparam int E_W    = 31;
  localparam int Q_W    = 49;
  localparam int MA_W   = 35;
  localparam int MB_W   = 31;
  localparam int PROD_W = 66;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  typedef enum logic [2:0] {
    T_IDLE,
    T_START,
    T_DECAY,
    T_LANES,
    T_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_DIV,
    D_EXP,
    D_FINAL
  } decay_state_t;

  typedef enum logic [3:0] {
    L_IDLE,
    L_WY_MUL,
    L_WY_DIV,
    L_J,
    L_JDT_MUL,
    L_WJ_MUL,
    L_WJ_DIV,
    L_WJDT_MUL,
    L_NY_MUL,
    L_NV_MUL
  } lane_state_t;

  typedef struct packed {
    logic start;
    logic snap;
  } cdsp_cmd_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bits;
    int i;
    rem  = v;
    res  = '0;
    bits = 64'd1 << 62;
    for (i = 0; i < 32; i++) begin
      if (rem >= res + bits) begin
        rem = rem - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  // factor 2^(-2^-k) in Q30
  function automatic logic [29:0] decay_const(input int k);
    logic [63:0] c;
    int i;
    c = isqrt64(64'd1 << 59);
    for (i = 1; i < k; i++) begin
      c = isqrt64(c << 30);
    end
    return c[29:0];
  endfunction

  localparam logic [29:0] DECAY_C [16] = '{
    decay_const(1),  decay_const(2),  decay_const(3),  decay_const(4),
    decay_const(5),  decay_const(6),  decay_const(7),  decay_const(8),
    decay_const(9),  decay_const(10), decay_const(11), decay_const(12),
    decay_const(13), decay_const(14), decay_const(15), decay_const(16)
  };

  function automatic logic signed [33:0] sat_wide(input logic signed [35:0] v);
    if (v > 36'sd8589934591) begin
      return 34'sh1_FFFF_FFFF;
    end else if (v < -36'sd8589934592) begin
      return 34'sh2_0000_0000;
    end else begin
      return v[33:0];
    end
  endfunction

  function automatic logic signed [31:0] sat_narrow(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // quotient magnitude with sign, truncated toward zero, clamped to 34 bits
  function automatic logic signed [33:0] sat_quot(input logic [48:0] q, input logic neg);
    if (neg) begin
      if (q > 49'd8589934592) begin
        return 34'sh2_0000_0000;
      end else begin
        return -$signed(q[33:0]);
      end
    end else if (q > 49'd8589934591) begin
      return 34'sh1_FFFF_FFFF;
    end else begin
      return $signed(q[33:0]);
    end
  endfunction

endpackage

FILE: hdl/critically_damped_spring_2d_top.sv
// Two-axis critically damped spring smoother.
// Slave stream: one item per tick carrying dt and the x/y target; the block
// keeps position and velocity per axis and returns the new position as one
// item on the master stream.
// half_life is written through half_life_we/half_life; the user must write it
// only while the block is idle (the block does not enforce this). A zero
// half_life snaps the position onto the target and clears the velocity. A
// snap item skips the decay factor and the lane arithmetic. Otherwise the
// decay factor needs a 32-step divide plus 16 multiply steps, then each axis
// lane runs two 49-step divides and six multiplies, each done in two halves.
// The x and y lanes run side by side in lockstep; one item is worked on at a
// time. A new item is taken as soon as the previous result sits in the output
// register, even if it is not yet taken. If the receiver stalls, the finished
// result waits in the output register and the next item waits before its own
// result is loaded. Reset clears positions and velocities to zero and sets
// half_life to one second (65536).
module critically_damped_spring_2d_top
  import cdsp_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            half_life_we,
  input  logic [HL_W-1:0] half_life,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [79:0]     s_axis_tdata,   // dt, target_x, target_y
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [63:0]     m_axis_tdata    // out_x, out_y
);

  top_state_t state, state_next;
  logic [HL_W-1:0]         hl;
  logic [DT_W-1:0]         dt;
  logic signed [POS_W-1:0] tx, ty, pos_x, pos_y;
  logic                    done_x, done_y;
  logic                    lane_done_x, lane_done_y;
  logic                    decay_start, decay_done;
  logic [E_W-1:0]          e;
  cdsp_cmd_t               lane_cmd;
  logic                    load_out;

  cdsp_decay u_decay (
    .clk   (clk),
    .rst   (rst),
    .start (decay_start),
    .dt    (dt),
    .hl    (hl),
    .done  (decay_done),
    .e     (e)
  );

  cdsp_lane u_lane_x (
    .clk    (clk),
    .rst    (rst),
    .cmd    (lane_cmd),
    .dt     (dt),
    .e      (e),
    .hl     (hl),
    .target (tx),
    .done   (lane_done_x),
    .pos    (pos_x)
  );

  cdsp_lane u_lane_y (
    .clk    (clk),
    .rst    (rst),
    .cmd    (lane_cmd),
    .dt     (dt),
    .e      (e),
    .hl     (hl),
    .target (ty),
    .done   (lane_done_y),
    .pos    (pos_y)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE:  if (s_axis_tvalid) state_next = T_START;
      T_START: state_next = (hl == '0) ? T_LANES : T_DECAY;
      T_DECAY: if (decay_done) state_next = T_LANES;
      T_LANES: if (done_x && done_y) state_next = T_OUT;
      T_OUT:   if (!m_axis_tvalid || m_axis_tready) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready  = (state == T_IDLE);
    decay_start    = (state == T_START) && (hl != '0);
    lane_cmd.snap  = (state == T_START);
    lane_cmd.start = ((state == T_START) && (hl == '0)) || decay_done;
    load_out       = (state == T_OUT) && (!m_axis_tvalid || m_axis_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      hl            <= 24'd65536;
      done_x        <= 1'b0;
      done_y        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (half_life_we) hl <= half_life;
      if (s_axis_tvalid && s_axis_tready) begin
        dt <= s_axis_tdata[15:0];
        tx <= s_axis_tdata[47:16];
        ty <= s_axis_tdata[79:48];
      end
      // merge the lane results, then drop the flags once loaded
      if (lane_done_x) done_x <= 1'b1;
      if (lane_done_y) done_y <= 1'b1;
      if (load_out) begin
        done_x        <= 1'b0;
        done_y        <= 1'b0;
        m_axis_tdata  <= {pos_y, pos_x};
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_flags_clear: assert property (@(posedge clk) disable iff (rst)
    (state == T_IDLE) |-> !(done_x || done_y))
    else $error("lane flags set while idle");

  a_decay_phase: assert property (@(posedge clk) disable iff (rst)
    decay_done |-> (state == T_DECAY))
    else $error("decay finished outside decay phase");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    lane_done_x |-> lane_done_y)
    else $error("lanes out of step");
`endif

endmodule

FILE: hdl/cdsp_div.sv
module cdsp_div #(
  parameter int NW = 49,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW);

  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW+1:0] diff;

  // trial subtract of the shifted partial remainder
  assign diff = {1'b0, rem, quo[NW-1]} - {2'b00, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        cnt  <= CW'(NW - 1);
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[NW-2:0], ~diff[DW+1]};
        rem <= diff[DW+1] ? {rem[DW-2:0], quo[NW-1]} : diff[DW-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/cdsp_decay.sv
module cdsp_decay
  import cdsp_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DT_W-1:0] dt,
  input  logic [HL_W-1:0] hl,
  output logic            done,
  output logic [E_W-1:0]  e
);

  decay_state_t state, state_next;
  logic [31:0]  r;
  logic         div_done;
  logic         div_start;
  logic [E_W-1:0] acc;
  logic [3:0]   cnt;
  logic [60:0]  eprod;

  cdsp_div #(.NW(32), .DW(HL_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({dt, 16'h0000}),
    .divisor  (hl),
    .done     (div_done),
    .quotient (r)
  );

  assign eprod = acc * DECAY_C[cnt];

  always_comb begin
    state_next = state;
    unique case (state)
      D_IDLE:  if (start) state_next = D_DIV;
      D_DIV:   if (div_done) state_next = D_EXP;
      D_EXP:   if (cnt == 4'd15) state_next = D_FINAL;
      D_FINAL: state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  always_comb begin
    div_start = (state == D_IDLE) && start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        D_DIV: begin
          acc <= E_W'(31'd1 << 30);
          cnt <= '0;
        end
        D_EXP: begin
          // one fraction bit of the ratio per cycle, most significant first
          if (r[5'd15 - {1'b0, cnt}]) acc <= eprod[60:30];
          cnt <= cnt + 1'b1;
        end
        D_FINAL: begin
          e    <= (r[31:16] >= 16'd31) ? '0 : (acc >> r[20:16]);
          done <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/cdsp_lane.sv
module cdsp_lane
  import cdsp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cdsp_cmd_t               cmd,
  input  logic [DT_W-1:0]         dt,
  input  logic [E_W-1:0]          e,
  input  logic [HL_W-1:0]         hl,
  input  logic signed [POS_W-1:0] target,
  output logic                    done,
  output logic signed [POS_W-1:0] pos
);

  lane_state_t state, state_next;
  logic phase;

  logic signed [POS_W-1:0]  vel;
  logic signed [WIDE_W-1:0] y, j, w, ydt, nv;
  logic signed [PROD_W-1:0] acc, prod, mul_sum;
  logic signed [MA_W-1:0]   ma, y_ext, j_ext;
  logic [MB_W-1:0]          mb;
  logic [15:0]              bpart;
  logic signed [51:0]       mprod;
  logic                     div_start, div_done;
  logic [Q_W-1:0]           quotient;

  cdsp_div #(.NW(Q_W), .DW(HL_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[62:14]),
    .divisor  (hl),
    .done     (div_done),
    .quotient (quotient)
  );

  assign y_ext = MA_W'(y);
  assign j_ext = MA_W'(j);

  // low half of the second operand first, high half on the next cycle
  assign bpart   = phase ? {1'b0, mb[30:16]} : mb[15:0];
  assign mprod   = ma * $signed({1'b0, bpart});
  assign mul_sum = acc + (PROD_W'(mprod) <<< 16);

  always_comb begin
    state_next = state;
    unique case (state)
      L_IDLE:     if (cmd.start && !cmd.snap) state_next = L_WY_MUL;
      L_WY_MUL:   if (phase) state_next = L_WY_DIV;
      L_WY_DIV:   if (phase && div_done) state_next = L_J;
      L_J:        state_next = L_JDT_MUL;
      L_JDT_MUL:  if (phase) state_next = L_WJ_MUL;
      L_WJ_MUL:   if (phase) state_next = L_WJ_DIV;
      L_WJ_DIV:   if (phase && div_done) state_next = L_WJDT_MUL;
      L_WJDT_MUL: if (phase) state_next = L_NY_MUL;
      L_NY_MUL:   if (phase) state_next = L_NV_MUL;
      L_NV_MUL:   if (phase) state_next = L_IDLE;
      default:    state_next = L_IDLE;
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      L_WY_MUL: begin
        ma = y[33] ? -y_ext : y_ext;
        mb = {1'b0, LN2_Q30};
      end
      L_JDT_MUL: begin
        ma = j_ext;
        mb = MB_W'(dt);
      end
      L_WJ_MUL: begin
        ma = j[33] ? -j_ext : j_ext;
        mb = {1'b0, LN2_Q30};
      end
      L_WJDT_MUL: begin
        ma = MA_W'(w);
        mb = MB_W'(dt);
      end
      L_NY_MUL: begin
        ma = MA_W'(ydt);
        mb = e;
      end
      L_NV_MUL: begin
        ma = MA_W'(nv);
        mb = e;
      end
      default: ;
    endcase
    div_start = ((state == L_WY_DIV) || (state == L_WJ_DIV)) && !phase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      phase <= 1'b0;
      done  <= 1'b0;
      pos   <= '0;
      vel   <= '0;
    end else begin
      state <= state_next;
      phase <= (state_next == state);
      done  <= 1'b0;
      if (!phase) acc <= PROD_W'(mprod);
      unique case (state)
        L_IDLE: begin
          if (cmd.start) begin
            if (cmd.snap) begin
              pos  <= target;
              vel  <= '0;
              done <= 1'b1;
            end else begin
              y <= WIDE_W'(pos) - WIDE_W'(target);
            end
          end
        end
        L_WY_MUL, L_WJ_MUL: if (phase) prod <= mul_sum;
        L_WY_DIV:   if (div_done) w <= sat_quot(quotient, y[33]);
        L_J:        j <= sat_wide(EXT_W'(vel) + EXT_W'(w));
        L_JDT_MUL:  if (phase) ydt <= sat_wide(EXT_W'(y) + $signed(mul_sum[51:16]));
        L_WJ_DIV:   if (div_done) w <= sat_quot(quotient, j[33]);
        L_WJDT_MUL: if (phase) nv <= sat_wide(EXT_W'(vel) - $signed(mul_sum[51:16]));
        L_NY_MUL:   if (phase) pos <= sat_narrow(EXT_W'(target) + $signed(mul_sum[65:30]));
        L_NV_MUL: begin
          if (phase) begin
            vel  <= sat_narrow($signed(mul_sum[65:30]));
            done <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
